/* hw/rtl/tch_pkg.sv */
// ---------------------------------------------------------------------------
// tch_pkg
// shared constants, types and the arctangent table of the heading pipeline
// ---------------------------------------------------------------------------
`default_nettype none

package tch_pkg;

    // iterations of each cordic chain (8..24)
    localparam int CORDIC_STAGES = 16;
    localparam int SHW           = 5;     // shift amount width, covers 24 stages
    localparam int CW            = 54;    // cordic x/y datapath width
    localparam int ZW            = 32;    // cordic angle width, 2^-20 degree
    localparam int HW            = 50;    // horizontal Q30 components
    localparam int LATENCY       = 2 * CORDIC_STAGES + 6;

    localparam logic signed [CW-1:0] GAIN_Q30  = CW'(64'sd652032874);
    localparam logic signed [ZW-1:0] QUARTER_Z = ZW'(32'sd94371840);
    localparam int FULL_TURN = 5760;

    typedef enum logic [1:0] {
        REG_X_OFFSET       = 2'd0,
        REG_Y_GAIN         = 2'd1,
        REG_Y_OFFSET       = 2'd2,
        REG_HEADING_OFFSET = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_vec_t;

    typedef struct packed {
        logic en;        // pipeline advance
        logic vec_mode;  // 1: vectoring (steer by y), 0: rotation (steer by z)
    } cell_ctl_t;

    // atan(2^-i) in 2^-20 degree
    function automatic logic signed [ZW-1:0] atan_of(input logic [SHW-1:0] i);
        logic signed [ZW-1:0] r;
        case (i)
            5'd0:  r = 32'sd47185920;
            5'd1:  r = 32'sd27855475;
            5'd2:  r = 32'sd14718068;
            5'd3:  r = 32'sd7471121;
            5'd4:  r = 32'sd3750058;
            5'd5:  r = 32'sd1876857;
            5'd6:  r = 32'sd938658;
            5'd7:  r = 32'sd469357;
            5'd8:  r = 32'sd234682;
            5'd9:  r = 32'sd117342;
            5'd10: r = 32'sd58671;
            5'd11: r = 32'sd29335;
            5'd12: r = 32'sd14668;
            5'd13: r = 32'sd7334;
            5'd14: r = 32'sd3667;
            5'd15: r = 32'sd1833;
            5'd16: r = 32'sd917;
            5'd17: r = 32'sd458;
            5'd18: r = 32'sd229;
            5'd19: r = 32'sd115;
            5'd20: r = 32'sd57;
            5'd21: r = 32'sd29;
            5'd22: r = 32'sd14;
            5'd23: r = 32'sd7;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/tch_cordic_cell.sv */
// ---------------------------------------------------------------------------
// tch_cordic_cell
// one registered cordic micro-rotation, rotation or vectoring mode
// ---------------------------------------------------------------------------
`default_nettype none

module tch_cordic_cell (
    input  wire logic                         clk,
    input  wire tch_pkg::cell_ctl_t           ctl,
    input  wire logic [tch_pkg::SHW-1:0]      shift,
    input  wire logic signed [tch_pkg::ZW-1:0] atan,
    input  wire tch_pkg::cordic_vec_t         din,
    output tch_pkg::cordic_vec_t              dout
);

    tch_pkg::cordic_vec_t      vec_reg;
    tch_pkg::cordic_vec_t      vec_next;
    logic signed [tch_pkg::CW-1:0] xs;
    logic signed [tch_pkg::CW-1:0] ys;
    logic                      pos;

    always_comb
    begin
        xs  = $signed(din.x) >>> shift;
        ys  = $signed(din.y) >>> shift;
        // steer towards zero angle (rotation) or zero y (vectoring)
        pos = ctl.vec_mode ? din.y[tch_pkg::CW-1] : ~din.z[tch_pkg::ZW-1];
        if (pos)
        begin
            vec_next.x = $signed(din.x) - ys;
            vec_next.y = $signed(din.y) + xs;
            vec_next.z = $signed(din.z) - atan;
        end
        else
        begin
            vec_next.x = $signed(din.x) + ys;
            vec_next.y = $signed(din.y) - xs;
            vec_next.z = $signed(din.z) + atan;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            vec_reg <= vec_next;
        end
    end

    assign dout = vec_reg;

endmodule

`default_nettype wire

/* hw/rtl/tilt_compensated_heading.sv */
// the beat passes stage a, the sin/cos chains, stages r, m1, m2 and v, the atan2 chain, output
// throughput: one beat per cycle unless stalled; every stage is a register, no iteration
// the whole pipeline advances unless a result waits with out_stall high,
// so in_stall is the stalled output beat
// reset clears the beat valid flags and loads the calibration defaults
// ---------------------------------------------------------------------------
// tilt_compensated_heading
// calibrates a magnetometer sample, removes roll and pitch and forms the
// heading with two sin/cos cordic chains and an atan2 cordic chain
// ---------------------------------------------------------------------------
`default_nettype none

module tilt_compensated_heading (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [14:0]        cfg_data,
    // input beat
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [12:0] raw_x,
    input  wire logic signed [12:0] raw_y,
    input  wire logic signed [12:0] raw_z,
    input  wire logic signed [12:0] roll_angle,
    input  wire logic signed [12:0] pitch_angle,
    // result beat
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [12:0]             heading,
    output logic signed [14:0]      horiz_x,
    output logic signed [14:0]      horiz_y,
    output logic                    in_range
);

    localparam int N   = tch_pkg::CORDIC_STAGES;
    localparam int LAT = tch_pkg::LATENCY;
    localparam int CW  = tch_pkg::CW;
    localparam int ZW  = tch_pkg::ZW;
    localparam int HW  = tch_pkg::HW;

    // side data that rides along the sin/cos chain
    typedef struct packed {
        logic signed [13:0] mx;
        logic signed [14:0] my;
        logic signed [12:0] mz;
        logic               ok;
        logic               negr;
        logic               negp;
    } sc_side_t;

    // side data that rides along the atan2 chain
    typedef struct packed {
        logic signed [14:0] ox;
        logic signed [14:0] oy;
        logic               zero;
        logic               ok;
    } vec_side_t;

    // ---------------- configuration registers ----------------
    logic signed [11:0] x_offset_reg;
    logic [14:0]        y_gain_reg;
    logic signed [11:0] y_offset_reg;
    logic [12:0]        heading_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_offset_reg       <= 12'sd41;
            y_gain_reg         <= 15'd15401;
            y_offset_reg       <= 12'sd58;
            heading_offset_reg <= 13'd480;
        end
        else if (cfg_we)
        begin
            case (tch_pkg::cfg_reg_t'(cfg_index))
                tch_pkg::REG_X_OFFSET:       x_offset_reg       <= cfg_data[11:0];
                tch_pkg::REG_Y_GAIN:         y_gain_reg         <= cfg_data;
                tch_pkg::REG_Y_OFFSET:       y_offset_reg       <= cfg_data[11:0];
                tch_pkg::REG_HEADING_OFFSET: heading_offset_reg <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    // a single advance enable moves every stage together
    logic           adv;
    logic [LAT-1:0] valid_reg;
    logic [LAT-1:0] valid_next;

    assign adv        = ~(valid_reg[LAT-1] & out_stall);
    assign in_stall   = ~adv;
    assign out_valid  = valid_reg[LAT-1];
    assign valid_next = {valid_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    tch_pkg::cell_ctl_t rot_ctl;
    tch_pkg::cell_ctl_t vec_ctl;

    assign rot_ctl = '{en: adv, vec_mode: 1'b0};
    assign vec_ctl = '{en: adv, vec_mode: 1'b1};

    // ---------------- stage a: calibration and angle folding ----------------
    // fold an angle into -90..90 degrees, flagging a half-turn
    function automatic logic [14:0] fold(input logic signed [12:0] a);
        logic signed [13:0] t;
        logic               neg;
        t   = 14'(a);
        neg = 1'b0;
        if (t >= 14'sd2880)
            t = t - 14'sd5760;
        if (t < -14'sd2880)
            t = t + 14'sd5760;
        if (t > 14'sd1440)
        begin
            t   = t - 14'sd2880;
            neg = 1'b1;
        end
        if (t < -14'sd1440)
        begin
            t   = t + 14'sd2880;
            neg = 1'b1;
        end
        return {neg, t};
    endfunction

    logic [14:0] roll_f;
    logic [14:0] pitch_f;

    assign roll_f  = fold(roll_angle);
    assign pitch_f = fold(pitch_angle);

    logic signed [13:0]   mx_a_reg;
    logic signed [29:0]   prod_a_reg;
    logic signed [12:0]   mz_a_reg;
    logic                 ok_a_reg;
    logic                 negr_a_reg;
    logic                 negp_a_reg;
    tch_pkg::cordic_vec_t roll_a_reg;
    tch_pkg::cordic_vec_t pitch_a_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mx_a_reg   <= 14'(raw_x) + 14'(x_offset_reg);
            prod_a_reg <= 30'(raw_y * $signed({1'b0, y_gain_reg}));
            mz_a_reg   <= raw_z;
            ok_a_reg   <= (raw_x[12] == raw_x[11]) && (raw_y[12] == raw_y[11])
                          && (raw_z[12] == raw_z[11]);
            negr_a_reg <= roll_f[14];
            negp_a_reg <= pitch_f[14];
            roll_a_reg <= '{x: tch_pkg::GAIN_Q30, y: '0,
                            z: ZW'($signed(roll_f[13:0])) <<< 16};
            pitch_a_reg <= '{x: tch_pkg::GAIN_Q30, y: '0,
                             z: ZW'($signed(pitch_f[13:0])) <<< 16};
        end
    end

    // scaled y, truncated toward zero
    logic signed [30:0] ysum;
    logic signed [30:0] ybias;
    logic signed [14:0] my_a;

    assign ysum  = 31'(prod_a_reg) + (31'(y_offset_reg) <<< 14);
    assign ybias = ysum + (ysum[30] ? 31'sd16383 : 31'sd0);
    assign my_a  = 15'(ybias >>> 14);

    // ---------------- sin/cos chains of roll and pitch ----------------
    tch_pkg::cordic_vec_t roll_c  [N+1];
    tch_pkg::cordic_vec_t pitch_c [N+1];
    sc_side_t             sc_side_reg [N];

    assign roll_c[0]  = roll_a_reg;
    assign pitch_c[0] = pitch_a_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sc_side_reg[0] <= '{mx: mx_a_reg, my: my_a, mz: mz_a_reg, ok: ok_a_reg,
                                negr: negr_a_reg, negp: negp_a_reg};
            for (int k = 1; k < N; k++)
            begin
                sc_side_reg[k] <= sc_side_reg[k-1];
            end
        end
    end

    for (genvar g = 0; g < N; g++)
    begin : g_sc
        tch_cordic_cell u_roll (
            .clk   (clk),
            .ctl   (rot_ctl),
            .shift (tch_pkg::SHW'(g)),
            .atan  (tch_pkg::atan_of(tch_pkg::SHW'(g))),
            .din   (roll_c[g]),
            .dout  (roll_c[g+1])
        );
        tch_cordic_cell u_pitch (
            .clk   (clk),
            .ctl   (rot_ctl),
            .shift (tch_pkg::SHW'(g)),
            .atan  (tch_pkg::atan_of(tch_pkg::SHW'(g))),
            .din   (pitch_c[g]),
            .dout  (pitch_c[g+1])
        );
    end

    // ---------------- stage r: round to q1.15, clamp, undo fold ----------------
    function automatic logic signed [16:0] to_q15(input logic signed [CW-1:0] v,
                                                  input logic neg);
        logic signed [CW-1:0] r;
        logic signed [16:0]   c;
        r = (v + CW'(16384)) >>> 15;
        if (r > CW'(32767))
            c = 17'sd32767;
        else if (r < -CW'(32767))
            c = -17'sd32767;
        else
            c = 17'(r);
        return neg ? -c : c;
    endfunction

    logic signed [16:0] sr_reg;
    logic signed [16:0] cr_reg;
    logic signed [16:0] sp_reg;
    logic signed [16:0] cp_reg;
    sc_side_t           side_r_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sr_reg     <= to_q15(roll_c[N].y,  sc_side_reg[N-1].negr);
            cr_reg     <= to_q15(roll_c[N].x,  sc_side_reg[N-1].negr);
            sp_reg     <= to_q15(pitch_c[N].y, sc_side_reg[N-1].negp);
            cp_reg     <= to_q15(pitch_c[N].x, sc_side_reg[N-1].negp);
            side_r_reg <= sc_side_reg[N-1];
        end
    end

    // ---------------- stage m1: first products ----------------
    logic signed [30:0] pa_reg;   // mx*cp
    logic signed [31:0] pb_reg;   // my*sr
    logic signed [29:0] pc_reg;   // mz*cr
    logic signed [31:0] pd_reg;   // my*cr
    logic signed [29:0] pe_reg;   // mz*sr
    logic signed [16:0] sp_m_reg;
    logic               ok_m_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg   <= 31'(side_r_reg.mx * cp_reg);
            pb_reg   <= 32'(side_r_reg.my * sr_reg);
            pc_reg   <= 30'(side_r_reg.mz * cr_reg);
            pd_reg   <= 32'(side_r_reg.my * cr_reg);
            pe_reg   <= 30'(side_r_reg.mz * sr_reg);
            sp_m_reg <= sp_reg;
            ok_m_reg <= side_r_reg.ok;
        end
    end

    // ---------------- stage m2: horizontal components in q30 ----------------
    logic signed [HW-1:0] hx_reg;
    logic signed [HW-1:0] hy_reg;
    logic                 ok_h_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hx_reg   <= (HW'(pa_reg) <<< 15) - HW'(pb_reg * sp_m_reg)
                        + HW'(pc_reg * sp_m_reg);
            hy_reg   <= (HW'(pd_reg) + HW'(pe_reg)) <<< 15;
            ok_h_reg <= ok_m_reg;
        end
    end

    // ---------------- stage v: counts output, quadrant fold ----------------
    function automatic logic signed [14:0] to_counts(input logic signed [HW-1:0] v);
        logic signed [HW-1:0] q;
        q = (v + (v[HW-1] ? HW'(64'sd1073741823) : HW'(0))) >>> 30;
        if (q > HW'(16383))
            return 15'sd16383;
        else if (q < -HW'(16384))
            return -15'sd16384;
        else
            return 15'(q);
    endfunction

    tch_pkg::cordic_vec_t vin;
    tch_pkg::cordic_vec_t vec_a_reg;
    vec_side_t            vside_a_reg;

    always_comb
    begin
        vin = '{x: CW'(hx_reg), y: CW'(hy_reg), z: '0};
        if (hx_reg[HW-1])
        begin
            if (!hy_reg[HW-1])
                vin = '{x: CW'(hy_reg), y: -CW'(hx_reg), z: tch_pkg::QUARTER_Z};
            else
                vin = '{x: -CW'(hy_reg), y: CW'(hx_reg), z: -tch_pkg::QUARTER_Z};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vec_a_reg   <= vin;
            vside_a_reg <= '{ox: to_counts(hx_reg), oy: to_counts(hy_reg),
                             zero: (hx_reg == '0) && (hy_reg == '0), ok: ok_h_reg};
        end
    end

    // ---------------- atan2 chain ----------------
    tch_pkg::cordic_vec_t vec_c [N+1];
    vec_side_t            vside_reg [N];

    assign vec_c[0] = vec_a_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vside_reg[0] <= vside_a_reg;
            for (int k = 1; k < N; k++)
            begin
                vside_reg[k] <= vside_reg[k-1];
            end
        end
    end

    for (genvar g = 0; g < N; g++)
    begin : g_vec
        tch_cordic_cell u_vec (
            .clk   (clk),
            .ctl   (vec_ctl),
            .shift (tch_pkg::SHW'(g)),
            .atan  (tch_pkg::atan_of(tch_pkg::SHW'(g))),
            .din   (vec_c[g]),
            .dout  (vec_c[g+1])
        );
    end

    // ---------------- output stage: round, declination, wrap ----------------
    logic signed [ZW-1:0] zr;
    logic signed [16:0]   ang;
    logic signed [16:0]   hsum;
    logic signed [16:0]   hwrap;

    always_comb
    begin
        zr   = (vec_c[N].z + ZW'(32768)) >>> 16;
        ang  = vside_reg[N-1].zero ? 17'sd0 : 17'(zr);
        hsum = ang + 17'($signed({1'b0, heading_offset_reg}));
        if (hsum[16])
            hwrap = hsum + 17'(tch_pkg::FULL_TURN);
        else if (hsum >= 17'(tch_pkg::FULL_TURN))
            hwrap = hsum - 17'(tch_pkg::FULL_TURN);
        else
            hwrap = hsum;
    end

    logic [12:0]        heading_reg;
    logic signed [14:0] horiz_x_reg;
    logic signed [14:0] horiz_y_reg;
    logic               in_range_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            heading_reg  <= hwrap[12:0];
            horiz_x_reg  <= vside_reg[N-1].ox;
            horiz_y_reg  <= vside_reg[N-1].oy;
            in_range_reg <= vside_reg[N-1].ok;
        end
    end

    assign heading  = heading_reg;
    assign horiz_x  = horiz_x_reg;
    assign horiz_y  = horiz_y_reg;
    assign in_range = in_range_reg;

endmodule

`default_nettype wire

/* hw/rtl/tch_checker.sv */
// ---------------------------------------------------------------------------
// tch_checker
// port-level checks of the heading pipeline, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

module tch_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic [12:0]        heading,
    input wire logic signed [14:0] horiz_x,
    input wire logic signed [14:0] horiz_y,
    input wire logic               in_range
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(heading)
        && $stable(horiz_x) && $stable(horiz_y) && $stable(in_range))
        else $error("result beat changed while stalled");

    // input side only stalls behind a waiting result beat
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with no waiting result");

    // heading always wrapped into one turn
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> heading < 13'd5760)
        else $error("heading outside 0..5759");

endmodule

bind tilt_compensated_heading tch_checker u_tch_checker (.*);

`default_nettype wire
